// ----- design/smf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int WINDOW      = 5;
   localparam int SAMPLE_W    = 12;
   localparam int TDATA_W     = 16;
   localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int MEDIAN_RANK = WINDOW / 2;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUSH
   } smf_state_type;

   typedef struct packed {
      logic write;
      logic scan_next;
      logic capture;
      logic load_out;
   } smf_cmd_type;

   typedef struct packed {
      logic hit;
      logic out_busy;
   } smf_status_type;

endpackage

// ----- design/smf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_ctrl
// Controller: accepts a sample, steps the rank scan, hands off the result.
// ----------------------------------------------------------------------------
module smf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  smf_pkg::smf_status_type sts,
   output smf_pkg::smf_cmd_type    cmd
);
   import smf_pkg::*;

   smf_state_type state_ff;
   smf_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.write  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan_next = 1'b1;
            cmd.capture   = sts.hit;
         end
         ST_PUSH: begin
            cmd.load_out = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/smf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_dp
// Datapath: circular window, rank scan over candidates, output register.
// ----------------------------------------------------------------------------
module smf_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  smf_pkg::sample_type     sample,
   input  smf_pkg::smf_cmd_type    cmd,
   output smf_pkg::smf_status_type sts,
   output smf_pkg::sample_type     median,
   output logic                    rsp_valid,
   input  logic                    rsp_ready
);
   import smf_pkg::*;

   localparam idx_type LAST_IDX = IDX_W'(WINDOW - 1);
   localparam cnt_type RANK     = CNT_W'(MEDIAN_RANK);

   sample_type              win_ff [WINDOW];
   idx_type                 ptr_ff;
   idx_type                 ptr_in;
   idx_type                 idx_ff;
   idx_type                 idx_in;
   sample_type              med_ff;
   sample_type              out_ff;
   logic                    valid_ff;
   logic                    valid_in;
   sample_type              cand;
   logic [WINDOW-1:0]       lt_vec;
   logic [WINDOW-1:0]       le_vec;
   cnt_type                 lt_cnt;
   cnt_type                 le_cnt;

   // rank of the candidate against every entry
   always_comb begin
      cand = win_ff[idx_ff];
      for (int j = 0; j < WINDOW; j++) begin
         lt_vec[j] = (win_ff[j] < cand);
         le_vec[j] = (win_ff[j] <= cand);
      end
      lt_cnt = CNT_W'($countones(lt_vec));
      le_cnt = CNT_W'($countones(le_vec));
   end

   assign sts.hit      = ((lt_cnt <= RANK) && (le_cnt > RANK)) || (idx_ff == LAST_IDX);
   assign sts.out_busy = valid_ff && !rsp_ready;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.write) begin
         ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.write) begin
         idx_in = '0;
      end else if (cmd.scan_next && (idx_ff != LAST_IDX)) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WINDOW; j++) begin
            win_ff[j] <= '0;
         end
         ptr_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.write) begin
            win_ff[ptr_ff] <= sample;
         end
         ptr_ff   <= ptr_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         med_ff <= cand;
      end
      if (cmd.load_out) begin
         out_ff <= med_ff;
      end
   end

   assign median    = out_ff;
   assign rsp_valid = valid_ff;

endmodule

// ----- design/sliding_window_median_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Running median over a circular window of 12-bit samples.
//
// Usage:
//   req_ channel: one 12-bit sample per transaction. The sample overwrites
//   the oldest window entry. rsp_ channel: one median per transaction, the
//   element of rank WINDOW/2 of the window after insertion.
//   The controller takes a sample, then scans candidates one per cycle,
//   counting entries below and not above each one with a compare row
//   across the window. The scan stops at the first candidate of the median
//   rank. req_tready returns in the same cycle that the result reaches
//   rsp_tvalid; a new sample is taken only after the last result is loaded.
//   Reset clears the window to zeros and the write pointer to the first
//   entry; early medians count those zeros.
//   A stalled rsp_ channel holds its transaction in the output register;
//   the next sample is still accepted and scanned, and its result waits
//   until the output register is taken.
// ----------------------------------------------------------------------------
module sliding_window_median_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [smf_pkg::TDATA_W-1:0]   req_tdata,   // [11:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [smf_pkg::TDATA_W-1:0]   rsp_tdata    // [11:0] median
);
   import smf_pkg::*;

   smf_cmd_type    cmd;
   smf_status_type sts;
   sample_type     median;

   smf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   smf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .sample    (req_tdata[SAMPLE_W-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .median    (median),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {{(TDATA_W - SAMPLE_W){1'b0}}, median};

endmodule

// ----- dv/sliding_window_median_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter_tb
// Self-checking bench for the running median over a circular sample window.
//
// A short table of directed samples runs right after reset, covering the
// zero-filled early window, full-scale samples, equal samples and single-bit
// patterns. Shaped random runs follow: uniform, constant, full-scale,
// ramps and small noise around a level. A local model of the window and
// write pointer predicts each median, and every rsp_ transaction is checked
// in order. Both channels stall at random in phases one and two; in phase
// three, the output is held off for one long stretch so the input backs up.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_tb;

   import smf_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 10;
   localparam int ITEMS_PER_PH  = 300;
   localparam int HOLD_OFF_LEN  = 400;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 4 * WINDOW + 8;
   localparam int MAX_REPORTS   = 10;
   localparam int N_DIRECTED    = 21;

   typedef enum int {
      PAT_UNIFORM,
      PAT_CONSTANT,
      PAT_FULL_SCALE,
      PAT_RAMP,
      PAT_NOISY
   } pattern_type;

   typedef struct packed {
      sample_type sample;
      logic       typed;
      sample_type median;
   } directed_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [TDATA_W-1:0]   rsp_tdata;

   sample_type model_window [WINDOW];
   int         model_wr_ptr;
   sample_type pending_medians [$];

   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold_off_request;
   int   error_count;
   int   samples_sent;
   int   medians_checked;
   int   input_stall_run;
   int   longest_input_stall;
   int   quiet_cycles;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{12'hFFF, 1'b1, 12'h000},
      '{12'hFFF, 1'b1, 12'h000},
      '{12'hFFF, 1'b1, 12'hFFF},
      '{12'h000, 1'b1, 12'hFFF},
      '{12'h000, 1'b1, 12'hFFF},
      '{12'h000, 1'b1, 12'h000},
      '{12'h007, 1'b0, 12'h000},
      '{12'h007, 1'b0, 12'h000},
      '{12'h007, 1'b0, 12'h000},
      '{12'h007, 1'b0, 12'h000},
      '{12'h007, 1'b1, 12'h007},
      '{12'h001, 1'b0, 12'h000},
      '{12'h800, 1'b0, 12'h000},
      '{12'h7FF, 1'b0, 12'h000},
      '{12'h555, 1'b0, 12'h000},
      '{12'hAAA, 1'b0, 12'h000},
      '{12'hFFE, 1'b0, 12'h000},
      '{12'h123, 1'b0, 12'h000},
      '{12'hFFF, 1'b0, 12'h000},
      '{12'hFFF, 1'b0, 12'h000},
      '{12'h000, 1'b0, 12'h000}
   };

   sliding_window_median_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [11:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [11:0] median
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Insert one sample into the model window and return the median rank.
   function automatic sample_type insert_and_rank(input sample_type s);
      sample_type sorted_win [WINDOW];
      sample_type key;
      int         j;
      if (model_wr_ptr >= WINDOW) begin
         model_wr_ptr = 0;
      end
      model_window[model_wr_ptr] = s;
      model_wr_ptr = (model_wr_ptr + 1 >= WINDOW) ? 0 : model_wr_ptr + 1;
      sorted_win = model_window;
      for (int i = 1; i < WINDOW; i++) begin
         key = sorted_win[i];
         j   = i;
         while (j > 0 && sorted_win[j-1] > key) begin
            sorted_win[j] = sorted_win[j-1];
            j--;
         end
         sorted_win[j] = key;
      end
      return sorted_win[MEDIAN_RANK];
   endfunction

   // Entered and left at a falling edge; valid stays high between back-to-back
   // transactions.
   task automatic send_sample(input sample_type s, input logic typed,
                              input sample_type typed_median);
      sample_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {{(TDATA_W - SAMPLE_W){1'b0}}, s};
      do @(posedge clock); while (!req_tready);
      predicted = insert_and_rank(s);
      pending_medians.push_back(typed ? typed_median : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_samples(input int n_items);
      pattern_type pattern;
      int          run_len;
      int          k;
      int          step;
      sample_type  level;
      sample_type  s;
      k = 0;
      while (k < n_items) begin
         pattern = pattern_type'($urandom_range(0, 4));
         run_len = $urandom_range(1, 12);
         level   = sample_type'($urandom);
         step    = int'($urandom_range(0, 64)) - 32;
         for (int r = 0; r < run_len && k < n_items; r++) begin
            case (pattern)
               PAT_UNIFORM: begin
                  s = sample_type'($urandom);
               end
               PAT_CONSTANT: begin
                  s = level;
               end
               PAT_FULL_SCALE: begin
                  s = ($urandom_range(0, 1) != 0) ? '1 : '0;
               end
               PAT_RAMP: begin
                  s = level + sample_type'(step * r);
               end
               default: begin
                  s = level ^ sample_type'($urandom_range(0, 15));
               end
            endcase
            send_sample(s, 1'b0, '0);
            k++;
         end
      end
   endtask

   // Output side: random stalls, plus one long hold-off on request.
   initial begin
      int   stall_left;
      logic hold_off_done;
      stall_left    = 0;
      hold_off_done = 1'b0;
      rsp_tready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            stall_left    = HOLD_OFF_LEN;
            hold_off_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check each median against the oldest prediction.
   always @(posedge clock) begin
      sample_type expected_median;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_medians.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("%0t: unexpected median 0x%03h", $realtime,
                        rsp_tdata[SAMPLE_W-1:0]);
            end
         end else begin
            expected_median = pending_medians.pop_front();
            medians_checked++;
            if (rsp_tdata[SAMPLE_W-1:0] !== expected_median) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: median mismatch, expected 0x%03h, actual 0x%03h",
                           $realtime, expected_median, rsp_tdata[SAMPLE_W-1:0]);
               end
            end
         end
      end
   end

   // Track input back-pressure and end the run if nothing moves.
   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) begin
         input_stall_run++;
         if (input_stall_run > longest_input_stall) begin
            longest_input_stall = input_stall_run;
         end
      end else begin
         input_stall_run = 0;
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d medians outstanding",
                     $realtime, STALL_LIMIT, pending_medians.size());
            $display("[sliding_window_median_filter] ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_tvalid          = 1'b0;
      req_tdata           = '0;
      hold_off_request    = 1'b0;
      send_idle_pct       = 25;
      recv_idle_pct       = 66;
      error_count         = 0;
      samples_sent        = 0;
      medians_checked     = 0;
      input_stall_run     = 0;
      longest_input_stall = 0;
      quiet_cycles        = 0;
      model_wr_ptr        = 0;
      for (int i = 0; i < WINDOW; i++) begin
         model_window[i] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_sample(directed_rows[i].sample, directed_rows[i].typed,
                     directed_rows[i].median);
      end
      send_random_samples(ITEMS_PER_PH);

      send_idle_pct = 66;
      recv_idle_pct = 25;
      send_random_samples(ITEMS_PER_PH);

      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_off_request = 1'b1;
      send_random_samples(ITEMS_PER_PH);
      req_tvalid = 1'b0;

      wait (pending_medians.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d samples (%0d directed) through a %0d-entry window, checked %0d medians.",
               samples_sent, N_DIRECTED, WINDOW, medians_checked);
      $display("Longest input back-pressure: %0d cycles; mismatches: %0d.",
               longest_input_stall, error_count);
      if (error_count == 0 && pending_medians.size() == 0) begin
         $display("[sliding_window_median_filter] OK");
      end else begin
         $display("[sliding_window_median_filter] ERROR");
      end
      $finish;
   end

endmodule
